FILE: design/u2u_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 decoder.
// No dependencies; imported by every module of the block.
package u2u_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned UnitW   = 16;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 16;

  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_BAD_SEQ   = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NO_SPACE  = 2'd2;
  localparam logic [StatusW-1:0] STATUS_TRUNCATED = 2'd3;

  localparam logic [ByteW-1:0] BOM_BYTE0 = 8'hEF;
  localparam logic [ByteW-1:0] BOM_BYTE1 = 8'hBB;
  localparam logic [ByteW-1:0] BOM_BYTE2 = 8'hBF;

  localparam logic [1:0] POS_NONE   = 2'd0;
  localparam logic [1:0] POS_SECOND = 2'd1;
  localparam logic [1:0] POS_THIRD  = 2'd2;
  localparam logic [1:0] POS_LATER  = 2'd3;

  localparam int unsigned TdataInW  = 8;
  localparam int unsigned TdataOutW = 24;

  typedef struct packed {
    logic [ByteW-1:0] byte_value;
    logic             first_byte;
    logic             last_byte;
  } item_t;

  typedef struct packed {
    logic [1:0]         bytes_pending;
    logic [UnitW-1:0]   partial_value;
    logic [1:0]         byte_position;
    logic               mark_candidate;
    logic [CountW-1:0]  units_written;
    logic               failed;
    logic [StatusW-1:0] fail_code;
  } str_state_t;

  typedef struct packed {
    logic [UnitW-1:0]   code_unit;
    logic               unit_valid;
    logic [StatusW-1:0] status;
    logic               end_of_string;
  } result_t;

endpackage

FILE: design/u2u_in_reg.sv
// Input register stage of the UTF-8 decoder: holds one accepted byte beat.
// Depends on u2u_pkg.
module u2u_in_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  u2u_pkg::item_t        item_i,
  input  logic                  take_i,
  output logic                  valid_o,
  output u2u_pkg::item_t        item_o
);
  import u2u_pkg::*;

  logic  valid_q, valid_d;
  item_t item_q;
  logic  load;

  // Accept when empty or when the held beat leaves this cycle.
  assign s_axis_tready = !valid_q || take_i;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

FILE: design/u2u_step.sv
// Combinational decode step: string state plus one byte gives next state and result.
// Depends on u2u_pkg.
module u2u_step (
  input  u2u_pkg::str_state_t     state_i,
  input  u2u_pkg::item_t          item_i,
  input  logic [15:0]             capacity_i,
  output u2u_pkg::str_state_t     state_o,
  output u2u_pkg::result_t        result_o,
  output logic                    emit_o
);
  import u2u_pkg::*;

  str_state_t       base;
  str_state_t       nxt;
  logic             fresh;
  logic             done;
  logic             valid;
  logic [UnitW-1:0] unit;
  logic [UnitW-1:0] shifted;
  logic [ByteW-1:0] b;
  logic [1:0]       pos;

  assign b = item_i.byte_value;

  always_comb begin
    base  = state_i;
    fresh = 1'b0;
    // Open a new string on a first mark or when none is open.
    if (item_i.first_byte || (state_i.byte_position == POS_NONE)) begin
      base = '0;
      if (capacity_i == '0) begin
        base.failed    = 1'b1;
        base.fail_code = STATUS_NO_SPACE;
        fresh          = 1'b1;
      end
    end
    pos     = base.byte_position;
    nxt     = base;
    done    = 1'b0;
    valid   = 1'b0;
    unit    = '0;
    shifted = {base.partial_value[UnitW-7:0], b[5:0]};

    if (!base.failed) begin
      if (base.bytes_pending == 2'd0) begin
        if (!b[7]) begin
          unit = {8'h00, b};
          done = 1'b1;
        end else if (!b[6]) begin
          nxt.failed    = 1'b1;
          nxt.fail_code = STATUS_BAD_SEQ;
          fresh         = 1'b1;
        end else if (b[5]) begin
          nxt.partial_value = {12'h000, b[3:0]};
          nxt.bytes_pending = 2'd2;
        end else begin
          nxt.partial_value = {11'h000, b[4:0]};
          nxt.bytes_pending = 2'd1;
        end
      end else begin
        if (b[7:6] != 2'b10) begin
          nxt.failed    = 1'b1;
          nxt.fail_code = STATUS_BAD_SEQ;
          fresh         = 1'b1;
        end else begin
          nxt.partial_value = shifted;
          nxt.bytes_pending = base.bytes_pending - 2'd1;
          if (base.bytes_pending == 2'd1) begin
            unit = shifted;
            done = 1'b1;
          end
        end
      end

      case (pos)
        POS_NONE:   nxt.mark_candidate = (b == BOM_BYTE0);
        POS_SECOND: nxt.mark_candidate = base.mark_candidate && (b == BOM_BYTE1);
        POS_THIRD:  nxt.mark_candidate = base.mark_candidate && (b == BOM_BYTE2);
        default:    nxt.mark_candidate = 1'b0;
      endcase

      // Drop a leading byte-order mark unless it is the whole string.
      if (done && (pos == POS_THIRD) && nxt.mark_candidate && !item_i.last_byte) begin
        done = 1'b0;
      end

      if (done) begin
        if (base.units_written >= capacity_i) begin
          nxt.failed    = 1'b1;
          nxt.fail_code = STATUS_NO_SPACE;
          fresh         = 1'b1;
        end else begin
          nxt.units_written = base.units_written + 16'd1;
          valid             = 1'b1;
        end
      end

      if (!nxt.failed && item_i.last_byte && (nxt.bytes_pending != 2'd0)) begin
        nxt.failed    = 1'b1;
        nxt.fail_code = STATUS_TRUNCATED;
        fresh         = 1'b1;
      end
    end

    if (pos != POS_LATER) begin
      nxt.byte_position = pos + 2'd1;
    end

    result_o.code_unit     = valid ? unit : '0;
    result_o.unit_valid    = valid;
    result_o.status        = nxt.failed ? nxt.fail_code : STATUS_OK;
    result_o.end_of_string = item_i.last_byte;
    emit_o                 = valid || fresh || item_i.last_byte;

    state_o = item_i.last_byte ? '0 : nxt;
  end

endmodule

FILE: design/u2u_out_reg.sv
// Output register stage of the UTF-8 decoder: holds one result beat for the receiver.
// Depends on u2u_pkg.
module u2u_out_reg (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  load_i,
  input  u2u_pkg::result_t      result_i,
  output logic                  ready_o,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output u2u_pkg::result_t      result_o
);
  import u2u_pkg::*;

  logic    valid_q, valid_d;
  result_t result_q;

  // Room when empty or when the held beat is taken this cycle.
  assign ready_o = !valid_q || m_axis_tready;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (m_axis_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign m_axis_tvalid = valid_q;
  assign result_o      = result_q;

endmodule

FILE: design/utf8_to_ucs2_decoder.sv
// Top level of the UTF-8 to UCS-2 decoder: input stage, decode step, string state,
// capacity register and output stage. Depends on u2u_pkg, u2u_in_reg, u2u_step, u2u_out_reg.
//
// Usage
//   Slave stream: one UTF-8 byte per beat in tdata[7:0]; tuser marks the first byte of a
//   string and tlast its final byte. A byte with no string open starts a new one.
//   Master stream: tdata carries the code unit and the sticky status, tuser says the
//   code unit is valid, tlast marks the result for a string's last byte. A byte yields a
//   result when it completes a unit, when it first raises an error, or when it is last;
//   other bytes are consumed silently.
//   Configuration: cfg_we_i writes cfg_wdata_i into unit_capacity at the clock edge;
//   write it only while the block is idle. Reset value is 65535.
//   Path: an accepted byte is held in the input register, decoded by the combinational
//   step, and its result loaded into the output register, visible on the master side.
//   Throughput: one byte per cycle unless the receiver stalls a result; the decode step is a
//   single short combinational pass between the input register and the output register.
//   Stall: when the receiver holds tready low with a result pending, a silent byte still
//   advances; a byte with a result waits in the input register, and the slave tready
//   drops once that register is full and cannot drain.
//   Reset: asynchronous, active low; clears both stages, all string state, and sets the
//   capacity to 65535.
module utf8_to_ucs2_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Slave side
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [u2u_pkg::TdataInW-1:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic                          s_axis_tuser,   // first_byte
  input  logic                          s_axis_tlast,   // last_byte
  // Master side
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [u2u_pkg::TdataOutW-1:0] m_axis_tdata,   // [15:0] code_unit, [17:16] status
  output logic                          m_axis_tuser,   // unit_valid
  output logic                          m_axis_tlast,   // end_of_string
  // Configuration
  input  logic                          cfg_we_i,
  input  logic [15:0]                   cfg_wdata_i     // unit_capacity
);
  import u2u_pkg::*;

  item_t      in_item;
  item_t      held_item;
  logic       held_valid;
  logic       take;
  str_state_t state_q, state_d;
  str_state_t step_state;
  result_t    step_result;
  result_t    out_result;
  logic       emit;
  logic       out_ready;
  logic [15:0] capacity_q;

  assign in_item.byte_value = s_axis_tdata[ByteW-1:0];
  assign in_item.first_byte = s_axis_tuser;
  assign in_item.last_byte  = s_axis_tlast;

  u2u_in_reg u_in (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .item_i        (in_item),
    .take_i        (take),
    .valid_o       (held_valid),
    .item_o        (held_item)
  );

  u2u_step u_step (
    .state_i    (state_q),
    .item_i     (held_item),
    .capacity_i (capacity_q),
    .state_o    (step_state),
    .result_o   (step_result),
    .emit_o     (emit)
  );

  // Retire the held byte unless its result has nowhere to go.
  assign take    = held_valid && (!emit || out_ready);
  assign state_d = take ? step_state : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= 16'hFFFF;
    end else if (cfg_we_i) begin
      capacity_q <= cfg_wdata_i;
    end
  end

  u2u_out_reg u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (take && emit),
    .result_i      (step_result),
    .ready_o       (out_ready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .result_o      (out_result)
  );

  assign m_axis_tdata = {6'b000000, out_result.status, out_result.code_unit};
  assign m_axis_tuser = out_result.unit_valid;
  assign m_axis_tlast = out_result.end_of_string;

endmodule
